// ===== rtl/core/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// tss_pkg
// Shared constants, types and codes of the three-sum search block.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int unsigned MaxItemsDefault  = 4096;
  localparam int unsigned ValueBitsDefault = 30;
  localparam int unsigned PosBits          = 13;
  localparam int unsigned TargetBits       = 30;
  localparam int unsigned InValueBits      = 30;
  localparam int unsigned PaddrBits        = 3;

  // Byte address of the target register.
  localparam logic [PaddrBits-1:0] AddrTarget = 3'd0;

  // Sequencer states.
  typedef enum logic [3:0] {
    StIdle,
    StInsRead,
    StInsCmp,
    StSrchPivot,
    StSrchPivWait,
    StSrchRead,
    StSrchWait,
    StSrchCmp,
    StOut
  } state_e;

endpackage : tss_pkg

// ===== rtl/core/three_sum_search.sv =====
// ----------------------------------------------------------------------------
// three_sum_search
// Loads values into a sorted store by insertion, then runs a two-pointer
// three-sum search over the store after the last item of a set.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transfer content
//  s_axis    in         tdata = value, tlast = last_item
//  m_axis    out        tdata = found, first/second/third_position, overflowed
//  apb       in/out     target_sum at byte address 0
//
//  Loading an item shifts each entry above its sorted place up by one,
//  reading and writing one entry at a time through the store's one read
//  port. The search walks, for each pivot, its pointer pair with up to two
//  store reads and one shared add and compare per step. The input is not
//  ready while an item is at work or a result waits. Reset is asynchronous;
//  the store itself is never cleared.
// ----------------------------------------------------------------------------
module three_sum_search
  import tss_pkg::*;
#(
  parameter int unsigned MaxItems  = MaxItemsDefault,
  parameter int unsigned ValueBits = ValueBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [31:0]            s_axis_tdata,   // [29:0] value
  input  logic                   s_axis_tlast,   // last_item
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [47:0]            m_axis_tdata,   // found, first, second, third, overflowed
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PaddrBits-1:0]   paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int unsigned IdxBits = $clog2(MaxItems);
  localparam int unsigned CntBits = $clog2(MaxItems + 1);
  localparam int unsigned SumBits = ValueBits + 2;
  localparam int unsigned EntBits = ValueBits + CntBits;

  // Configuration register.
  logic [TargetBits-1:0] target_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (psel && penable && pwrite && (paddr == AddrTarget)) begin
      target_q <= pwdata[TargetBits-1:0];
    end
  end
  assign pready = 1'b1;
  assign prdata = (paddr == AddrTarget) ? {{(32-TargetBits){1'b0}}, target_q} : '0;

  // Sorted store: value in the high bits, arrival position in the low bits.
  logic [EntBits-1:0] mem_q [MaxItems];
  logic [EntBits-1:0] rdata_q;
  logic               we;
  logic [IdxBits-1:0] waddr, raddr;
  logic [EntBits-1:0] wdata;
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  state_e               state_q, state_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic                 ovf_q, ovf_d;
  logic [ValueBits-1:0] val_q, val_d;
  logic                 last_q, last_d;
  logic [CntBits-1:0]   k_q, k_d;       // insertion slot
  logic [CntBits-1:0]   i_q, i_d;       // pivot
  logic [CntBits-1:0]   l_q, l_d, r_q, r_d;
  logic                 side_q, side_d; // 0: left read pending
  logic [EntBits-1:0]   lent_q, lent_d;
  logic [SumBits-1:0]   want_q, want_d; // signed
  logic [CntBits-1:0]   piv_pos_q, piv_pos_d;
  logic                 res_v_q, res_v_d;
  logic [47:0]          res_q, res_d;

  logic [ValueBits-1:0] rd_val, l_val;
  logic [SumBits-1:0]   pair_sum;
  assign rd_val   = rdata_q[EntBits-1:CntBits];
  assign l_val    = lent_q[EntBits-1:CntBits];
  assign pair_sum = {2'b00, l_val} + {2'b00, rd_val};

  function automatic logic [PosBits-1:0] pos13(input logic [CntBits-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    return w[PosBits-1:0];
  endfunction

  // Sequencer.
  always_comb begin
    state_d = state_q; cnt_d = cnt_q; ovf_d = ovf_q; val_d = val_q; last_d = last_q;
    k_d = k_q; i_d = i_q; l_d = l_q; r_d = r_q; side_d = side_q; lent_d = lent_q;
    want_d = want_q; piv_pos_d = piv_pos_q; res_v_d = res_v_q; res_d = res_q;
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    s_axis_tready = (state_q == StIdle) && !res_v_q;
    if (res_v_q && m_axis_tready) res_v_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          val_d  = s_axis_tdata[ValueBits-1:0];
          last_d = s_axis_tlast;
          k_d    = cnt_q;
          if (cnt_q == CntBits'(MaxItems)) begin
            ovf_d = 1'b1;
            if (s_axis_tlast) begin
              i_d = '0; state_d = StSrchPivot;
            end
          end else begin
            state_d = StInsRead;
          end
        end
      end
      StInsRead: begin
        if (k_q == '0) begin
          we = 1'b1; waddr = '0; wdata = {val_q, CntBits'(cnt_q + 1'b1)};
          cnt_d = cnt_q + 1'b1;
          i_d = '0;
          state_d = last_q ? StSrchPivot : StIdle;
        end else begin
          raddr = IdxBits'(k_q - 1'b1);
          state_d = StInsCmp;
        end
      end
      StInsCmp: begin
        if (rd_val > val_q) begin
          we = 1'b1; waddr = IdxBits'(k_q); wdata = rdata_q;
          k_d = k_q - 1'b1;
          state_d = StInsRead;
        end else begin
          we = 1'b1; waddr = IdxBits'(k_q); wdata = {val_q, CntBits'(cnt_q + 1'b1)};
          cnt_d = cnt_q + 1'b1;
          i_d = '0;
          state_d = last_q ? StSrchPivot : StIdle;
        end
      end
      StSrchPivot: begin
        if (i_q >= cnt_q) begin
          res_d = {7'd0, ovf_q, 13'd0, 13'd0, 13'd0, 1'b0};
          state_d = StOut;
        end else begin
          raddr = IdxBits'(i_q);
          state_d = StSrchPivWait;
        end
      end
      StSrchPivWait: begin
        want_d    = SumBits'(target_q) - {2'b00, rd_val};
        piv_pos_d = rdata_q[CntBits-1:0];
        l_d = '0; r_d = cnt_q - 1'b1; side_d = 1'b0;
        state_d = StSrchRead;
      end
      StSrchRead: begin
        if (l_q >= r_q) begin
          i_d = i_q + 1'b1; state_d = StSrchPivot;
        end else if (l_q == i_q) begin
          l_d = l_q + 1'b1;
        end else if (r_q == i_q) begin
          r_d = r_q - 1'b1;
        end else begin
          raddr = side_q ? IdxBits'(r_q) : IdxBits'(l_q);
          state_d = StSrchWait;
        end
      end
      StSrchWait: begin
        if (!side_q) begin
          lent_d = rdata_q; side_d = 1'b1; state_d = StSrchRead;
        end else begin
          // Keep the right entry on the read data for the compare.
          raddr = IdxBits'(r_q);
          state_d = StSrchCmp;
        end
      end
      StSrchCmp: begin
        if (pair_sum == want_q) begin
          res_d = {7'd0, ovf_q, pos13(piv_pos_q), pos13(rdata_q[CntBits-1:0]),
                   pos13(lent_q[CntBits-1:0]), 1'b1};
          state_d = StOut;
        end else if ($signed(pair_sum) < $signed(want_q)) begin
          l_d = l_q + 1'b1; side_d = 1'b0; state_d = StSrchRead;
        end else begin
          r_d = r_q - 1'b1; state_d = StSrchRead;
        end
      end
      StOut: begin
        if (!res_v_q) begin
          res_v_d = 1'b1; cnt_d = '0; ovf_d = 1'b0; state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; cnt_q <= '0; ovf_q <= 1'b0; res_v_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; ovf_q <= ovf_d; res_v_q <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d; last_q <= last_d; k_q <= k_d; i_q <= i_d; l_q <= l_d; r_q <= r_d;
    side_q <= side_d; lent_q <= lent_d; want_q <= want_d; piv_pos_q <= piv_pos_d;
    res_q <= res_d;
  end

  assign m_axis_tvalid = res_v_q;
  assign m_axis_tdata  = res_q;

endmodule : three_sum_search

// ===== rtl/core/tss_checker.sv =====
// ----------------------------------------------------------------------------
// tss_checker
// Port-level checks of the three-sum search block.
// ----------------------------------------------------------------------------
module tss_checker
  import tss_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  // A pending result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // No new input is taken while a result waits.
  a_no_in_with_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while result pending");

  // A miss reports zero positions.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[39:1] == 39'd0)
    else $error("positions set on a miss");

  // A hit reports nonzero positions.
  a_hit_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[13:1] != 13'd0)
    else $error("zero position on a hit");

endmodule : tss_checker

bind three_sum_search tss_checker u_tss_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
